// ===== hdl/hsci_pkg.sv =====
package hsci_pkg;

    localparam int unsigned DEF_MAX_ROWS          = 1024;
    localparam int unsigned DEF_GAUSS_TABLE_DEPTH = 256;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJECT_MODE = 2'd1;

    localparam logic [15:0] BLEND_RESET = 16'd16384;
    localparam logic [15:0] GAMMA_ONE   = 16'd32768;

    // Standardized values span 0..Z_SPAN over the table; Z_SPAN is 2**ZSPAN_LOG2.
    localparam logic [63:0] Z_SPAN     = 64'd8;
    localparam int unsigned ZSPAN_LOG2 = 3;

    localparam logic [63:0] LOG2E_Q30      = 64'd1549082005;
    localparam logic [63:0] HOLES_NORM_Q30 = 64'd422484487;
    localparam logic [63:0] SKEW_NORM_Q30  = 64'd388957607;

    localparam int unsigned DIV_STEPS = 64;

    // 2**(-2**-i) for i = 1..16 in Q.30.
    localparam logic [63:0] POW_HALF_FRAC [16] = '{
        64'd759250125,  64'd902905651,  64'd984625594,  64'd1028218693,
        64'd1050733751, 64'd1062175491, 64'd1067942999, 64'd1070838486,
        64'd1072289172, 64'd1073015252, 64'd1073378480, 64'd1073560135,
        64'd1073650976, 64'd1073696399, 64'd1073719111, 64'd1073730468
    };

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_MEAN_DIV,
        S_REM_SQ,
        S_CORR_START,
        S_CORR_DIV,
        S_SQ_READ,
        S_SQ_DIFF,
        S_SQ_MUL,
        S_SQ_ACC,
        S_VAR_START,
        S_VAR_DIV,
        S_SQRT,
        S_SD_CHECK,
        S_NSD,
        S_Z_READ,
        S_Z_VN,
        S_Z_DIFF,
        S_Z_MLO,
        S_Z_MHI,
        S_Z_NUM,
        S_Z_DIV,
        S_Z_ROM,
        S_Z_KG,
        S_Z_MOM,
        S_Z_NEXT,
        S_H_START,
        S_H_DIV,
        S_H_DIV2,
        S_A_PREP,
        S_A_DIV,
        S_A_DIV2
    } t_state;

    typedef enum logic [1:0] {
        B_MUL_HOLES,
        B_MUL_SKEW,
        B_SUM,
        B_DONE
    } t_blend_step;

    // 2**(-t) with t in Q.16, result in Q.16 (at most 65536).
    function automatic logic [16:0] gauss_exp2(input logic [63:0] t);
        logic [63:0] ip;
        logic [63:0] acc;
        logic [63:0] sh;
        ip  = t >> 16;
        acc = 64'd1 << 30;
        if (ip > 64'd16) begin
            return 17'd0;
        end
        for (int i = 0; i < 16; i++) begin
            if (t[15-i]) begin
                acc = (acc * POW_HALF_FRAC[i] + (64'd1 << 29)) >> 30;
            end
        end
        sh = 64'd14 + ip;
        return 17'((acc + (64'd1 << (sh - 64'd1))) >> sh);
    endfunction

endpackage

// ===== hdl/holes_skew_combined_index_core.sv =====
// Projection-pursuit holes and skewness index with a gamma blend. Matrix
// elements arrive one beat at a time, row by row, each with the weight of its
// column; tlast closes a row and tuser closes the matrix. Loading takes one
// cycle per beat. Each row is reduced to a Q.6 projected value (weighted sum,
// or the first element in first-column mode) and kept in an on-chip row
// memory; rows past MAX_ROWS are dropped and reported as overflow. The beat
// that closes the matrix starts the evaluation, during which the input is not
// ready: mean and remainder by one division, a sum of squared deviations (read,
// difference, square, accumulate per row), a variance division and a 32-step
// square root, then per row a table index found by a 64-step division and a
// Gaussian table lookup, and finally four divisions and a blend. Nearly all
// of the evaluation runs in the single 64-step shared divider; a 33x33
// multiplier is shared by every evaluation product. One result beat follows per
// matrix and waits in an output register while the next matrix loads.
module holes_skew_combined_index_core #(
    parameter int unsigned MAX_ROWS          = hsci_pkg::DEF_MAX_ROWS,
    parameter int unsigned GAUSS_TABLE_DEPTH = hsci_pkg::DEF_GAUSS_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hsci_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    // Element stream.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [31:0]                    i_s_axis_tdata, // data_value, weight
    input  logic                           i_s_axis_tlast, // last_in_row
    input  logic                           i_s_axis_tuser, // last_item
    // Result stream.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [47:0]                    o_m_axis_tdata, // combined, holes, skew
    output logic [1:0]                     o_m_axis_tuser  // degenerate, overflow
);
    import hsci_pkg::*;

    localparam int unsigned NW  = $clog2(MAX_ROWS + 1);
    localparam int unsigned AW  = $clog2(MAX_ROWS);
    localparam int unsigned VW  = 32 + NW;
    localparam int unsigned KW  = $clog2(GAUSS_TABLE_DEPTH);
    localparam int unsigned GW  = NW + 17;
    localparam int unsigned MW  = NW + KW + 18;
    localparam int unsigned EW  = 33 + NW;
    localparam int unsigned ES  = EW + 1;
    localparam int unsigned SW  = NW + 32;
    localparam logic [63:0] DEP = 64'(GAUSS_TABLE_DEPTH);

    // Gaussian table, exp(-z*z/2) in Q.16, built at elaboration.
    logic [16:0] w_gtab [GAUSS_TABLE_DEPTH];
    for (genvar gi = 0; gi < GAUSS_TABLE_DEPTH; gi++) begin : g_tab
        localparam logic [63:0] TNUM = Z_SPAN * Z_SPAN * 64'(gi) * 64'(gi) * LOG2E_Q30;
        localparam logic [63:0] TQ16 =
            (TNUM / (64'd2 * DEP * DEP) + 64'd8192) >> 14;
        assign w_gtab[gi] = gauss_exp2(TQ16);
    end

    function automatic logic [15:0] sat16(input logic [63:0] x);
        return (|x[63:16]) ? 16'hFFFF : x[15:0];
    endfunction

    t_state r_state, n_state;

    // Configuration.
    logic [15:0] r_blend;
    logic        r_mode;

    // Matrix state.
    logic signed [39:0]   r_acc;
    logic                 r_row_start;
    logic [NW-1:0]        r_cnt;
    logic signed [VW-1:0] r_vsum;
    logic [63:0]          r_ssum;
    logic [GW-1:0]        r_gsum;
    logic signed [MW-1:0] r_msum;
    logic                 r_ovf;
    logic [31:0]          r_mem [MAX_ROWS];
    logic signed [31:0]   r_rd;

    // Evaluation state.
    logic [NW-1:0]        r_idx;
    logic signed [32:0]   r_mean;
    logic [NW-1:0]        r_rem;
    logic [63:0]          r_corr;
    logic [31:0]          r_sd;
    logic [SW-1:0]        r_nsd;
    logic [EW-1:0]        r_mag;
    logic                 r_neg;
    logic [63:0]          r_num;
    logic [KW-1:0]        r_k;
    logic [16:0]          r_g;
    logic                 r_degen;
    logic [15:0]          r_holes;
    logic [15:0]          r_skew;
    logic [15:0]          r_comb;
    t_blend_step          r_bstep;

    // Shared divider.
    logic [63:0] r_dq, r_dr, r_dd;
    logic [6:0]  r_dcnt;
    // Shared multiplier.
    logic [65:0] r_prod;
    // Square root.
    logic [63:0] r_sx, r_sres, r_sbit;

    // Output register.
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic [1:0]  r_out_user;

    logic        w_in_ready, w_in_acc, w_end_row, w_store;
    logic        w_div_start, w_div_done, w_out_load, w_last_row;
    logic [63:0] w_div_num, w_div_den;
    logic [32:0] w_mul_a, w_mul_b;

    logic signed [15:0] w_d, w_w;
    logic signed [31:0] w_dw;
    logic signed [39:0] w_acc_base, w_acc_new;
    logic signed [31:0] w_v;
    logic [63:0]        w_vsum_abs;
    logic [15:0]        w_gm;
    logic [MW-1:0]      w_mmag;
    logic [GW-1:0]      w_deficit;
    logic [64:0]        w_sq_sum;
    logic [63:0]        w_ssum_net;
    logic signed [33:0] w_sq_e;
    logic signed [ES-1:0] w_vn, w_ze;
    logic [32:0]        w_rd_abs;
    logic [64:0]        w_drs;
    logic               w_dge;
    logic [63:0]        w_st;
    logic [66:0]        w_bl_sum;

    assign w_d        = i_s_axis_tdata[15:0];
    assign w_w        = i_s_axis_tdata[31:16];
    assign w_dw       = w_d * w_w;
    assign w_in_acc   = i_s_axis_tvalid && w_in_ready;
    assign w_end_row  = i_s_axis_tlast || i_s_axis_tuser;
    assign w_store    = w_in_acc && w_end_row && (r_cnt < NW'(MAX_ROWS));
    assign w_acc_base = r_row_start ? 40'sd0 : r_acc;

    always_comb begin
        if (r_mode) begin
            w_acc_new = w_acc_base + 40'(w_dw);
        end else if (r_row_start) begin
            w_acc_new = 40'(w_d) <<< 14;
        end else begin
            w_acc_new = r_acc;
        end
    end
    assign w_v = w_acc_new[39:8];

    assign w_div_done = (r_dcnt == 7'd0);
    assign w_last_row = (r_idx == r_cnt - NW'(1));
    assign w_gm       = (r_blend > GAMMA_ONE) ? GAMMA_ONE : r_blend;
    assign w_vsum_abs = r_vsum[VW-1] ? 64'(-r_vsum) : 64'(r_vsum);
    assign w_mmag     = r_msum[MW-1] ? MW'(-r_msum) : MW'(r_msum);
    assign w_deficit  = (GW'(r_cnt) << 16) - r_gsum;
    assign w_ssum_net = (r_ssum > r_corr) ? (r_ssum - r_corr) : 64'd0;
    assign w_sq_sum   = {1'b0, r_ssum} + r_prod[64:0];
    assign w_sq_e     = 34'(r_rd) - 34'(r_mean);
    assign w_rd_abs   = r_rd[31] ? (33'd0 - {1'b1, r_rd}) : {1'b0, r_rd};
    assign w_vn       = r_neg ? -$signed(ES'(r_prod)) : $signed(ES'(r_prod));
    assign w_ze       = w_vn - ES'(r_vsum);
    assign w_drs      = {r_dr, r_dq[63]};
    assign w_dge      = (w_drs >= {1'b0, r_dd});
    assign w_st       = r_sres + r_sbit;
    assign w_bl_sum   = 67'(r_num) + 67'(r_prod) + 67'd16384;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (w_in_acc && i_s_axis_tuser) n_state = S_CHECK;
            S_CHECK:      n_state = (r_cnt < NW'(2)) ? S_A_DIV2 : S_MEAN_DIV;
            S_MEAN_DIV:   if (w_div_done) n_state = S_REM_SQ;
            S_REM_SQ:     n_state = S_CORR_START;
            S_CORR_START: n_state = S_CORR_DIV;
            S_CORR_DIV:   if (w_div_done) n_state = S_SQ_READ;
            S_SQ_READ:    n_state = S_SQ_DIFF;
            S_SQ_DIFF:    n_state = S_SQ_MUL;
            S_SQ_MUL:     n_state = S_SQ_ACC;
            S_SQ_ACC:     n_state = w_last_row ? S_VAR_START : S_SQ_READ;
            S_VAR_START:  n_state = S_VAR_DIV;
            S_VAR_DIV:    if (w_div_done) n_state = S_SQRT;
            S_SQRT:       if (r_sbit == 64'd0) n_state = S_SD_CHECK;
            S_SD_CHECK:   n_state = (r_sd == 32'd0) ? S_A_DIV2 : S_NSD;
            S_NSD:        n_state = S_Z_READ;
            S_Z_READ:     n_state = S_Z_VN;
            S_Z_VN:       n_state = S_Z_DIFF;
            S_Z_DIFF:     n_state = S_Z_MLO;
            S_Z_MLO:      n_state = S_Z_MHI;
            S_Z_MHI:      n_state = S_Z_NUM;
            S_Z_NUM:      n_state = S_Z_DIV;
            S_Z_DIV: begin
                if (w_div_done) begin
                    n_state = (r_dq < DEP) ? S_Z_ROM : S_Z_NEXT;
                end
            end
            S_Z_ROM:      n_state = S_Z_KG;
            S_Z_KG:       n_state = S_Z_MOM;
            S_Z_MOM:      n_state = S_Z_NEXT;
            S_Z_NEXT:     n_state = w_last_row ? S_H_START : S_Z_READ;
            S_H_START:    n_state = S_H_DIV;
            S_H_DIV:      if (w_div_done) n_state = S_H_DIV2;
            S_H_DIV2:     if (w_div_done) n_state = S_A_PREP;
            S_A_PREP:     n_state = S_A_DIV;
            S_A_DIV:      if (w_div_done) n_state = S_A_DIV2;
            // Result collection: the blend, then the hand-off to the output register.
            S_A_DIV2: begin
                if (r_bstep == B_DONE && (r_degen || w_div_done) &&
                    (!r_out_valid || i_m_axis_tready)) begin
                    n_state = S_IDLE;
                end
            end
            default:      n_state = S_IDLE;
        endcase
    end

    // Control outputs: handshakes, divider and multiplier operands.
    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_div_num   = 64'd0;
        w_div_den   = 64'd1;
        w_mul_a     = 33'd0;
        w_mul_b     = 33'd0;
        w_out_load  = 1'b0;
        case (r_state)
            S_IDLE: w_in_ready = 1'b1;
            S_CHECK: begin
                w_div_start = (r_cnt >= NW'(2));
                w_div_num   = w_vsum_abs;
                w_div_den   = 64'(r_cnt);
            end
            S_REM_SQ: begin
                w_mul_a = 33'(r_rem);
                w_mul_b = 33'(r_rem);
            end
            S_CORR_START: begin
                w_div_start = 1'b1;
                w_div_num   = r_prod[63:0];
                w_div_den   = 64'(r_cnt);
            end
            S_SQ_MUL: begin
                w_mul_a = r_mag[32:0];
                w_mul_b = r_mag[32:0];
            end
            S_VAR_START: begin
                w_div_start = 1'b1;
                w_div_num   = w_ssum_net;
                w_div_den   = 64'(r_cnt - NW'(1));
            end
            S_SD_CHECK: begin
                w_mul_a = 33'(r_cnt);
                w_mul_b = 33'(r_sd);
            end
            S_Z_VN: begin
                w_mul_a = w_rd_abs;
                w_mul_b = 33'(r_cnt);
            end
            S_Z_MLO: begin
                w_mul_a = 33'(r_mag[31:0]);
                w_mul_b = 33'(DEP << 1);
            end
            S_Z_MHI: begin
                w_mul_a = 33'(r_mag >> 32);
                w_mul_b = 33'(DEP << 1);
            end
            S_Z_NUM: begin
                w_div_start = 1'b1;
                w_div_num   = (64'(r_prod) << 32) + r_num + (64'(r_nsd) << ZSPAN_LOG2);
                w_div_den   = 64'(r_nsd) << (ZSPAN_LOG2 + 1);
            end
            S_Z_KG: begin
                w_mul_a = 33'(r_k);
                w_mul_b = 33'(r_g);
            end
            S_H_START: begin
                w_div_start = 1'b1;
                w_div_num   = (64'(w_deficit) << 14) + 64'(r_cnt >> 1);
                w_div_den   = 64'(r_cnt);
            end
            S_H_DIV: begin
                w_div_start = w_div_done;
                w_div_num   = (r_dq << 14) + (HOLES_NORM_Q30 >> 1);
                w_div_den   = HOLES_NORM_Q30;
            end
            S_H_DIV2: begin
                w_mul_a = 33'(DEP);
                w_mul_b = 33'(r_cnt);
            end
            S_A_PREP: begin
                w_div_start = 1'b1;
                w_div_num   = (64'(w_mmag) << (ZSPAN_LOG2 + 14)) + (r_prod[63:0] >> 1);
                w_div_den   = r_prod[63:0];
            end
            S_A_DIV: begin
                w_div_start = w_div_done;
                w_div_num   = (r_dq << 14) + (SKEW_NORM_Q30 >> 1);
                w_div_den   = SKEW_NORM_Q30;
            end
            S_A_DIV2: begin
                case (r_bstep)
                    B_MUL_HOLES: begin
                        w_mul_a = 33'(w_gm);
                        w_mul_b = 33'(r_holes);
                    end
                    B_MUL_SKEW: begin
                        w_mul_a = 33'(GAMMA_ONE - w_gm);
                        w_mul_b = 33'(r_skew);
                    end
                    B_SUM: ;
                    B_DONE: w_out_load = (!r_out_valid || i_m_axis_tready);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Configuration port.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= BLEND_RESET;
            r_mode  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BLEND_WEIGHT: r_blend <= i_cfg_data;
                CFG_PROJECT_MODE: r_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Row memory.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_cnt[AW-1:0]] <= w_v;
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // Shared multiplier and Gaussian table read.
    always_ff @(posedge i_clk) begin
        r_prod <= 66'(w_mul_a) * 66'(w_mul_b);
        r_g    <= w_gtab[r_k];
    end

    // Shared divider: one restoring step per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= 7'd0;
        end else if (w_div_start) begin
            r_dq   <= w_div_num;
            r_dr   <= 64'd0;
            r_dd   <= w_div_den;
            r_dcnt <= 7'(DIV_STEPS);
        end else if (!w_div_done) begin
            r_dr   <= w_dge ? 64'(w_drs - {1'b0, r_dd}) : w_drs[63:0];
            r_dq   <= {r_dq[62:0], w_dge};
            r_dcnt <= r_dcnt - 7'd1;
        end
    end

    // Control state and matrix accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_row_start <= 1'b1;
            r_cnt       <= '0;
            r_vsum      <= '0;
            r_ssum      <= '0;
            r_gsum      <= '0;
            r_msum      <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_degen     <= 1'b1;
            r_bstep     <= B_MUL_HOLES;
            r_sbit      <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_acc       <= w_acc_new;
                        r_row_start <= w_end_row;
                        if (w_store) begin
                            r_vsum <= r_vsum + VW'(w_v);
                            r_cnt  <= r_cnt + NW'(1);
                        end else if (w_end_row) begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    r_degen <= 1'b1;
                    r_holes <= '0;
                    r_skew  <= '0;
                    r_comb  <= '0;
                    r_bstep <= B_DONE;
                end
                S_MEAN_DIV: begin
                    if (w_div_done) begin
                        if (!r_vsum[VW-1]) begin
                            r_mean <= $signed(33'(r_dq));
                            r_rem  <= r_dr[NW-1:0];
                        end else if (r_dr != 64'd0) begin
                            r_mean <= -$signed(33'(r_dq) + 33'd1);
                            r_rem  <= r_cnt - r_dr[NW-1:0];
                        end else begin
                            r_mean <= -$signed(33'(r_dq));
                            r_rem  <= '0;
                        end
                    end
                end
                S_CORR_DIV: begin
                    if (w_div_done) begin
                        r_corr <= r_dq;
                        r_idx  <= '0;
                    end
                end
                S_SQ_DIFF: begin
                    r_mag <= EW'(w_sq_e[33] ? 33'(-w_sq_e) : 33'(w_sq_e));
                end
                S_SQ_ACC: begin
                    r_ssum <= w_sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_sq_sum[63:0];
                    r_idx  <= r_idx + NW'(1);
                end
                S_VAR_DIV: begin
                    if (w_div_done) begin
                        r_sx   <= r_dq;
                        r_sres <= '0;
                        r_sbit <= 64'd1 << 62;
                    end
                end
                S_SQRT: begin
                    if (r_sbit != 64'd0) begin
                        if (r_sx >= w_st) begin
                            r_sx   <= r_sx - w_st;
                            r_sres <= (r_sres >> 1) + r_sbit;
                        end else begin
                            r_sres <= r_sres >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end else begin
                        r_sd <= r_sres[31:0];
                    end
                end
                S_SD_CHECK: begin
                    r_degen <= (r_sd == 32'd0);
                    r_bstep <= (r_sd == 32'd0) ? B_DONE : B_MUL_HOLES;
                end
                S_NSD: begin
                    r_nsd <= r_prod[SW-1:0];
                    r_idx <= '0;
                end
                S_Z_VN: r_neg <= r_rd[31];
                S_Z_DIFF: begin
                    r_neg <= w_ze[ES-1];
                    r_mag <= w_ze[ES-1] ? EW'(-w_ze) : EW'(w_ze);
                end
                S_Z_MHI: r_num <= r_prod[63:0];
                S_Z_DIV: if (w_div_done) r_k <= r_dq[KW-1:0];
                S_Z_KG:  r_gsum <= r_gsum + GW'(r_g);
                S_Z_MOM: begin
                    if (r_neg) begin
                        r_msum <= r_msum - $signed(MW'(r_prod));
                    end else begin
                        r_msum <= r_msum + $signed(MW'(r_prod));
                    end
                end
                S_Z_NEXT: r_idx <= r_idx + NW'(1);
                S_H_DIV2: if (w_div_done) r_holes <= sat16(r_dq);
                S_A_DIV2: begin
                    case (r_bstep)
                        B_MUL_HOLES: begin
                            if (!r_degen && w_div_done) begin
                                r_skew  <= sat16(r_dq);
                                r_bstep <= B_MUL_SKEW;
                            end
                        end
                        B_MUL_SKEW: begin
                            r_num   <= r_prod[63:0];
                            r_bstep <= B_SUM;
                        end
                        B_SUM: begin
                            r_comb  <= sat16(64'(w_bl_sum >> 15));
                            r_bstep <= B_DONE;
                        end
                        B_DONE: begin
                            if (w_out_load) begin
                                r_acc       <= '0;
                                r_row_start <= 1'b1;
                                r_cnt       <= '0;
                                r_vsum      <= '0;
                                r_ssum      <= '0;
                                r_gsum      <= '0;
                                r_msum      <= '0;
                                r_ovf       <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {r_skew, r_holes, r_comb};
            r_out_user <= {r_ovf, r_degen};
        end
    end

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    // The divider is only restarted once its previous quotient is complete.
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> w_div_done)
        else $error("divider restarted while busy");

    // The stored row count never exceeds the memory depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(MAX_ROWS))
        else $error("row count beyond capacity");

    // Handing a result out clears the matrix for the next one.
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_cnt == '0 && r_row_start && !r_ovf))
        else $error("matrix state not cleared after result");

    // A result is only loaded when the output register is free or draining.
    a_no_result_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || i_m_axis_tready))
        else $error("result overwritten before it was taken");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the holes/skewness index core.
//
// Matrices stream in one element per beat. A predictor in this module tracks
// the same row accumulation, row store, mean, spread and table lookups as the
// core. Each beat that closes a matrix queues one expected result beat. The
// result stream is compared field by field against that queue.
//
// Stimulus has three parts. A directed table covers single-row and zero-spread
// matrices, the extreme data and weight values, and a matrix closed by the
// last-item flag alone. Two long matrices then overflow the row store and wrap
// the 40-bit row accumulator. Random matrices follow, with the blend weight and
// the projection mode changed between them while the core is idle.
// Both stream sides insert random idle cycles, with bursts of back-to-back beats.
module tb_top;
    import hsci_pkg::*;

    localparam int unsigned ROW_CAP    = DEF_MAX_ROWS;
    localparam int unsigned TAB_DEPTH  = DEF_GAUSS_TABLE_DEPTH;
    localparam int unsigned STALL_LIMIT = 400000;
    localparam int unsigned RAND_ITEMS = 500;
    localparam int unsigned RAND_MATRICES = 40;
    // Register indexes 2 and 3 are not decoded by the core.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [15:0] combined;
        logic [15:0] holes;
        logic [15:0] skew;
        logic        degen;
        logic        ovf;
    } index_result_t;

    typedef struct {
        logic signed [15:0] data_value;
        logic signed [15:0] weight;
        bit                 row_end;
        bit                 matrix_end;
        bit                 typed;      // expected result written in the row
        index_result_t      typed_res;
    } element_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [31:0]          i_s_axis_tdata;   // data_value, weight
    logic                 i_s_axis_tlast;   // last_in_row
    logic                 i_s_axis_tuser;   // last_item
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [47:0]          o_m_axis_tdata;   // combined, holes, skew
    logic [1:0]           o_m_axis_tuser;   // degenerate, overflow

    holes_skew_combined_index_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: registers, row accumulation and the row store.
    // ------------------------------------------------------------------
    logic [15:0]          gamma_reg;
    bit                   weighted_mode;
    longint               row_acc;
    bit                   row_open_next;   // next element starts a new row
    int unsigned          rows_kept;
    longint               proj_sum;
    bit                   rows_dropped;
    int                   proj_store [ROW_CAP];
    longint unsigned      gauss_lut [TAB_DEPTH];

    index_result_t        pending_q [$];
    int unsigned          mismatch_cnt;
    int unsigned          results_seen;
    int unsigned          idle_cycles;
    bit                   send_burst;      // sender idles when clear
    bit                   recv_burst;      // receiver idles when clear

    // 2^(-t) with t in Q.16, result in Q.16.
    function automatic longint unsigned pow2_neg_q16(input longint unsigned t);
        longint unsigned whole;
        longint unsigned frac_acc;
        longint unsigned shift_amt;
        whole = t >> 16;
        frac_acc = 64'd1 << 30;
        if (whole > 16) begin
            return 0;
        end
        for (int b = 0; b < 16; b++) begin
            if (t[15-b]) begin
                frac_acc = (frac_acc * POW_HALF_FRAC[b] + (64'd1 << 29)) >> 30;
            end
        end
        shift_amt = 14 + whole;
        return (frac_acc + (64'd1 << (shift_amt - 1))) >> shift_amt;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned clip16(input longint unsigned x);
        return (x > 65535) ? 65535 : x;
    endfunction

    // Works out the index triple for the rows held so far.
    function automatic index_result_t evaluate_matrix();
        index_result_t   res;
        longint          n_s;
        longint          mean_v;
        longint          dev;
        longint unsigned n;
        longint unsigned rem;
        longint unsigned corr;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned sq_sum;
        longint unsigned sd;
        longint unsigned den;
        longint unsigned kidx;
        longint unsigned g_sum;
        longint          mom_sum;
        longint unsigned deficit;
        longint unsigned d30;
        longint unsigned a30;
        longint unsigned mmag;
        longint unsigned gm;
        longint unsigned holes_v;
        longint unsigned skew_v;
        longint unsigned comb_v;
        res = '0;
        res.degen = 1'b1;
        res.ovf = rows_dropped;
        n = rows_kept;
        sd = 0;
        sq_sum = 0;
        if (n >= 2) begin
            n_s = longint'(n);
            // Floor division of the sum by the row count.
            if (proj_sum >= 0) mean_v = proj_sum / n_s;
            else mean_v = -((-proj_sum + n_s - 1) / n_s);
            rem = longint'(proj_sum - mean_v * n_s);
            corr = (rem * rem) / n;
            for (int r = 0; r < n; r++) begin
                dev = longint'(proj_store[r]) - mean_v;
                mag = (dev < 0) ? longint'(-dev) : longint'(dev);
                sq = mag * mag;
                sq_sum = (sq_sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) ?
                         64'hFFFF_FFFF_FFFF_FFFF : sq_sum + sq;
            end
            sq_sum = (sq_sum > corr) ? sq_sum - corr : 0;
            sd = int_sqrt(sq_sum / (n - 1));
        end
        if (n >= 2 && sd != 0) begin
            res.degen = 1'b0;
            den = 2 * 8 * n * sd;
            g_sum = 0;
            mom_sum = 0;
            for (int r = 0; r < n; r++) begin
                dev = longint'(proj_store[r]) * longint'(n) - proj_sum;
                mag = (dev < 0) ? longint'(-dev) : longint'(dev);
                kidx = (2 * mag * TAB_DEPTH + 8 * n * sd) / den;
                if (kidx < TAB_DEPTH) begin
                    g_sum += gauss_lut[kidx];
                    if (dev < 0) mom_sum -= longint'(kidx * gauss_lut[kidx]);
                    else mom_sum += longint'(kidx * gauss_lut[kidx]);
                end
            end
            deficit = n * 65536 - g_sum;
            d30 = (deficit * 16384 + n / 2) / n;
            holes_v = clip16((d30 * 16384 + HOLES_NORM_Q30 / 2) / HOLES_NORM_Q30);
            mmag = (mom_sum < 0) ? longint'(-mom_sum) : longint'(mom_sum);
            a30 = (mmag * 8 * 16384 + (TAB_DEPTH * n) / 2) / (TAB_DEPTH * n);
            skew_v = clip16((a30 * 16384 + SKEW_NORM_Q30 / 2) / SKEW_NORM_Q30);
            gm = (gamma_reg > GAMMA_ONE) ? GAMMA_ONE : gamma_reg;
            comb_v = clip16((gm * holes_v + (32768 - gm) * skew_v + 16384) >> 15);
            res.holes = holes_v[15:0];
            res.skew = skew_v[15:0];
            res.combined = comb_v[15:0];
        end
        return res;
    endfunction

    // Advances the predictor by one accepted element. Returns 1 when the
    // element closes the matrix, with the expected result in res.
    function automatic bit absorb_element(input logic signed [15:0] dv,
                                          input logic signed [15:0] wt,
                                          input bit row_end, input bit matrix_end,
                                          output index_result_t res);
        longint sum40;
        res = '0;
        if (row_open_next) row_acc = 0;
        if (weighted_mode) begin
            // Keep the accumulator to 40-bit two's complement.
            sum40 = (row_acc + longint'(dv) * longint'(wt)) & 64'hFF_FFFF_FFFF;
            if (sum40[39]) sum40 = sum40 - (64'sd1 <<< 40);
            row_acc = sum40;
        end else if (row_open_next) begin
            row_acc = longint'(dv) * 16384;
        end
        if (row_end || matrix_end) begin
            if (rows_kept < ROW_CAP) begin
                proj_store[rows_kept] = int'(row_acc >>> 8);
                proj_sum += row_acc >>> 8;
                rows_kept++;
            end else begin
                rows_dropped = 1'b1;
            end
            row_open_next = 1'b1;
        end else begin
            row_open_next = 1'b0;
        end
        if (!matrix_end) begin
            return 1'b0;
        end
        res = evaluate_matrix();
        row_acc = 0;
        row_open_next = 1'b1;
        rows_kept = 0;
        proj_sum = 0;
        rows_dropped = 1'b0;
        return 1'b1;
    endfunction

    initial begin
        longint unsigned tpow;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            tpow = (64 * longint'(k) * longint'(k) * LOG2E_Q30)
                   / (2 * TAB_DEPTH * TAB_DEPTH);
            gauss_lut[k] = pow2_neg_q16((tpow + 8192) >> 14);
        end
    end

    function automatic int unsigned idle_draw(input bit burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    // Presents one element and returns after the beat is taken. A gap drops
    // tvalid; with no gap, tvalid stays high and only the payload changes.
    task automatic send_element(input logic signed [15:0] dv,
                                input logic signed [15:0] wt,
                                input bit row_end, input bit matrix_end,
                                input bit typed, input index_result_t typed_res);
        int unsigned   gap;
        index_result_t res;
        gap = idle_draw(send_burst);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {wt, dv};
        i_s_axis_tlast  <= row_end;
        i_s_axis_tuser  <= matrix_end;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (absorb_element(dv, wt, row_end, matrix_end, res)) begin
            pending_q.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic send_plain(input logic signed [15:0] dv, input logic signed [15:0] wt,
                              input bit row_end, input bit matrix_end);
        send_element(dv, wt, row_end, matrix_end, 1'b0, '0);
    endtask

    // The sender stops until every outstanding result beat has been taken.
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_q.size() != 0);
    endtask

    // After each write the configuration channel goes idle before the task returns.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_BLEND_WEIGHT) gamma_reg = val;
        else if (idx == CFG_PROJECT_MODE) weighted_mode = val[0];
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] draw_weight();
        return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endfunction

    function automatic logic signed [15:0] draw_data(input int unsigned flavor);
        case (flavor)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2047)) - 16'sd1024;
            default: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    // One random matrix: rows of 1 to max_cols elements. The closing element
    // carries the last-item flag, with or without the row flag.
    task automatic send_random_matrix(input int unsigned n_rows, input int unsigned max_cols,
                                      inout int unsigned sent);
        int unsigned cols;
        int unsigned flavor;
        bit          closing;
        flavor = ($urandom_range(0, 9) == 0) ? 2 : $urandom_range(0, 1);
        for (int r = 0; r < n_rows; r++) begin
            cols = $urandom_range(1, max_cols);
            for (int c = 0; c < cols; c++) begin
                closing = (r == n_rows - 1) && (c == cols - 1);
                send_plain(draw_data(flavor), draw_weight(),
                           closing ? 1'($urandom_range(0, 1)) : (c == cols - 1), closing);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side and result check.
    // ------------------------------------------------------------------
    task automatic check_result();
        index_result_t got;
        index_result_t want;
        got.combined = o_m_axis_tdata[15:0];
        got.holes    = o_m_axis_tdata[31:16];
        got.skew     = o_m_axis_tdata[47:32];
        got.degen    = o_m_axis_tuser[0];
        got.ovf      = o_m_axis_tuser[1];
        results_seen++;
        if (pending_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("unexpected result beat: comb %0d holes %0d skew %0d deg %0b ovf %0b",
                         got.combined, got.holes, got.skew, got.degen, got.ovf);
            end
            return;
        end
        want = pending_q.pop_front();
        if (got != want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("result %0d: expected comb %0d holes %0d skew %0d deg %0b ovf %0b",
                         results_seen, want.combined, want.holes, want.skew,
                         want.degen, want.ovf);
                $display("result %0d: actual   comb %0d holes %0d skew %0d deg %0b ovf %0b",
                         results_seen, got.combined, got.holes, got.skew,
                         got.degen, got.ovf);
            end
        end
    endtask

    initial begin
        int unsigned gap;
        i_m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = idle_draw(recv_burst);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            check_result();
        end
    end

    // Watchdog: the evaluation of a full row store is the longest quiet
    // stretch, and the limit leaves a wide margin over it.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table. Typed results are for degenerate matrices only.
    // ------------------------------------------------------------------
    localparam index_result_t DEGEN_RES = '{combined: 16'd0, holes: 16'd0, skew: 16'd0,
                                            degen: 1'b1, ovf: 1'b0};
    element_row_t directed [] = '{
        // Single row closed by the last-item flag: fewer than two rows.
        '{16'sh0100, 16'sh4000, 1'b1, 1'b1, 1'b1, DEGEN_RES},
        // Two identical rows: zero spread.
        '{16'sh0100, 16'sh4000, 1'b1, 1'b0, 1'b0, '0},
        '{16'sh0100, 16'sh4000, 1'b1, 1'b1, 1'b1, DEGEN_RES},
        // Extremes of data and weight in two-element rows, then single-element rows.
        '{16'sh8000, -16'sd16384, 1'b0, 1'b0, 1'b0, '0},
        '{16'sh7FFF, 16'sd16384, 1'b1, 1'b0, 1'b0, '0},
        '{16'sh8000, 16'sd16384, 1'b0, 1'b0, 1'b0, '0},
        '{16'sh7FFF, -16'sd16384, 1'b1, 1'b0, 1'b0, '0},
        '{16'sh0000, 16'sh0000, 1'b1, 1'b0, 1'b0, '0},
        '{16'shFFFF, 16'sh0001, 1'b1, 1'b0, 1'b0, '0},
        '{16'sh5555, 16'sh2AAA, 1'b1, 1'b0, 1'b0, '0},
        // The closing element ends its row through the last-item flag alone.
        '{16'shAAAA, -16'sd5462, 1'b0, 1'b1, 1'b0, '0},
        // A skewed set: one far row among close ones.
        '{16'sh0010, 16'sh4000, 1'b1, 1'b0, 1'b0, '0},
        '{16'sh0011, 16'sh4000, 1'b1, 1'b0, 1'b0, '0},
        '{16'sh0012, 16'sh4000, 1'b1, 1'b0, 1'b0, '0},
        '{16'sh0010, 16'sh4000, 1'b1, 1'b0, 1'b0, '0},
        '{16'sh7000, 16'sh4000, 1'b1, 1'b1, 1'b0, '0}
    };

    initial begin
        int unsigned sent;
        int unsigned n_matrices;
        int unsigned pick;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_BLEND_WEIGHT;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_s_axis_tuser  <= 1'b0;
        gamma_reg       = BLEND_RESET;
        weighted_mode   = 1'b1;
        row_acc         = 0;
        row_open_next   = 1'b1;
        rows_kept       = 0;
        proj_sum        = 0;
        rows_dropped    = 1'b0;
        mismatch_cnt    = 0;
        results_seen    = 0;
        idle_cycles     = 0;
        send_burst      = 1'b0;
        recv_burst      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset register values.
        foreach (directed[j]) begin
            send_element(directed[j].data_value, directed[j].weight, directed[j].row_end,
                         directed[j].matrix_end, directed[j].typed, directed[j].typed_res);
        end
        wait_results_drained();

        // Row store overflow: more single-element rows than the store holds.
        send_burst = 1'b1;
        recv_burst = 1'b1;
        for (int r = 0; r < ROW_CAP + 6; r++) begin
            send_plain(16'($urandom), draw_weight(), 1'b1, r == ROW_CAP + 5);
        end
        // Accumulator wrap: a row long enough to pass the 40-bit range.
        for (int c = 0; c < 1100; c++) begin
            send_plain(16'sh8000, -16'sd16384, c == 1099, 1'b0);
        end
        send_plain(16'sh0100, 16'sh0100, 1'b1, 1'b0);
        send_plain(16'sh7FFF, 16'sh4000, 1'b1, 1'b1);
        send_burst = 1'b0;
        recv_burst = 1'b0;
        wait_results_drained();

        // First-column mode with the blend fully on skew, then fully on holes.
        write_register(CFG_PROJECT_MODE, 16'd0);
        write_register(CFG_BLEND_WEIGHT, 16'd0);
        sent = 0;
        send_random_matrix(6, 3, sent);
        wait_results_drained();
        write_register(CFG_BLEND_WEIGHT, GAMMA_ONE);
        send_random_matrix(5, 4, sent);
        wait_results_drained();
        // Above 1.0 the blend weight is clamped; unused indexes change nothing.
        write_register(CFG_BLEND_WEIGHT, 16'hFFFF);
        write_register(CFG_UNUSED_A, 16'h0001);
        write_register(CFG_UNUSED_B, 16'hFFFF);
        write_register(CFG_PROJECT_MODE, 16'd1);
        send_random_matrix(7, 2, sent);
        wait_results_drained();

        // Random part. Registers are changed every few matrices while idle.
        sent = 0;
        n_matrices = 0;
        while (sent < RAND_ITEMS || n_matrices < RAND_MATRICES) begin
            if ($urandom_range(0, 3) == 0) send_burst = ~send_burst;
            if ($urandom_range(0, 3) == 0) recv_burst = ~recv_burst;
            if ($urandom_range(0, 7) == 0) begin
                wait_results_drained();
                pick = $urandom_range(0, 4);
                case (pick)
                    0: write_register(CFG_BLEND_WEIGHT, 16'd0);
                    1: write_register(CFG_BLEND_WEIGHT, GAMMA_ONE);
                    2: write_register(CFG_BLEND_WEIGHT, 16'($urandom));
                    default: write_register(CFG_BLEND_WEIGHT, 16'($urandom_range(0, 32768)));
                endcase
                write_register(CFG_PROJECT_MODE, 16'($urandom_range(0, 1)));
            end
            send_random_matrix(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8),
                               $urandom_range(1, 4), sent);
            n_matrices++;
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
